/* rtl/core/kls_pkg.sv */
// kls_pkg: shared constants, the cell-to-cell link type and the rank clamp
// for the k-th largest stream tracker. No dependencies.
package kls_pkg;

  localparam int MAX_RANK = 64;
  localparam int DATA_W   = 32;
  localparam int RANK_W   = 7;
  localparam int IDX_W    = $clog2(MAX_RANK);

  // what one cell shows its lower neighbor
  typedef struct packed {
    logic                     gt;   // new value goes ahead of this cell's value
    logic                     vld;  // cell holds a value inside the current rank
    logic signed [DATA_W-1:0] val;
  } link_t;

  // zero acts as one, anything above capacity acts as capacity
  function automatic logic [RANK_W-1:0] eff_rank(input logic [RANK_W-1:0] rank);
    logic [RANK_W-1:0] r;
    begin
      r = rank;
      if (rank == '0) begin
        r = RANK_W'(1);
      end else if (rank > RANK_W'(MAX_RANK)) begin
        r = RANK_W'(MAX_RANK);
      end
      return r;
    end
  endfunction

endpackage

/* rtl/core/kls_cell.sv */
// kls_cell: one slot of the sorted insertion chain; keeps one value and its
// valid bit, takes the upper neighbor's value when the new one lands above.
// Depends on kls_pkg.
module kls_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  logic                             in_rng,
  input  logic signed [kls_pkg::DATA_W-1:0] din,
  input  kls_pkg::link_t                   link_in,
  output kls_pkg::link_t                   link_out
);
  import kls_pkg::*;

  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     vld_r, vld_nxt;
  logic                     vld_eff;
  logic                     gt;

  // entries past the current rank count as empty
  assign vld_eff = vld_r & in_rng;
  assign gt      = !vld_eff || (din > val_r);

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (load) begin
      if (gt) begin
        val_nxt = link_in.gt ? link_in.val : din;
      end
      vld_nxt = in_rng & (vld_eff | link_in.vld);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign link_out = '{gt: gt, vld: vld_eff, val: val_r};

endmodule

/* rtl/core/kls_pick.sv */
// kls_pick: finds the last valid cell of the chain and its value, and the
// full flag from the cell at the current rank. Depends on kls_pkg.
module kls_pick (
  input  kls_pkg::link_t                    links [kls_pkg::MAX_RANK],
  input  logic [kls_pkg::RANK_W-1:0]        k_eff,
  output logic signed [kls_pkg::DATA_W-1:0] kth_value,
  output logic                              full_res
);
  import kls_pkg::*;

  logic [MAX_RANK-1:0] last;
  logic [MAX_RANK-1:0] vld_vec;
  logic [IDX_W-1:0]    k_idx;

  always_comb begin
    for (int i = 0; i < MAX_RANK; i++) begin
      vld_vec[i] = links[i].vld;
    end
    for (int i = 0; i < MAX_RANK - 1; i++) begin
      last[i] = links[i].vld & !links[i+1].vld;
    end
    last[MAX_RANK-1] = links[MAX_RANK-1].vld;
  end

  // and-or select, at most one bit of last is set
  always_comb begin
    kth_value = '0;
    for (int i = 0; i < MAX_RANK; i++) begin
      kth_value = kth_value | (links[i].val & {DATA_W{last[i]}});
    end
  end

  assign k_idx    = IDX_W'(k_eff - RANK_W'(1));
  assign full_res = vld_vec[k_idx];

endmodule

/* rtl/core/kth_largest_stream_tracker_core.sv */
// kth_largest_stream_tracker_core: top level; chain of kls_cell slots, the
// output selection in kls_pick and the output register. Depends on kls_pkg.
//
// Usage:
//   in_*  : one signed 32-bit value per transaction (in_tdata).
//   out_* : one result per input; out_tdata is the smallest retained value
//           (the k-th largest so far once full), out_tuser is the full flag.
//   cfg_* : writes rank_k (7 bits); always ready. Write only while idle, and
//           follow a rank change with a reset.
// On an accepted input transaction the chain of 64 cells does the sorted
// insertion, each cell comparing against the new value in parallel and taking
// its upper neighbor's value or the new one; the last-valid-cell select then
// loads the output register once that register is free, and result valid rises.
// Throughput is one item per cycle while out_tready is high.
// When the receiver stalls, one finished item waits in the chain and one in
// the output register; in_tready then drops until the output register
// frees up. Reset empties the chain and sets rank_k to 1; it takes effect
// in the same cycle, with no clearing pass.
module kth_largest_stream_tracker_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [kls_pkg::DATA_W-1:0]        in_tdata,   // [31:0] value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [kls_pkg::DATA_W-1:0]        out_tdata,  // [31:0] kth_value
  output logic                              out_tuser,  // [0] full_res
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kls_pkg::RANK_W-1:0]        cfg_data    // [6:0] rank_k
);
  import kls_pkg::*;

  logic [RANK_W-1:0]        rank_k_r, rank_k_nxt;
  logic [RANK_W-1:0]        k_eff;
  logic                     pend_r, pend_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_data_r, out_data_nxt;
  logic                     out_full_r, out_full_nxt;
  logic                     in_acc;
  logic                     out_load;
  logic [MAX_RANK-1:0]      rng;
  logic [MAX_RANK-1:0]      vld_vec;
  link_t                    links [MAX_RANK];
  link_t                    head;
  logic signed [DATA_W-1:0] pick_val;
  logic                     pick_full;

  assign cfg_ready  = 1'b1;
  assign rank_k_nxt = (cfg_valid && cfg_ready) ? cfg_data : rank_k_r;
  assign k_eff      = eff_rank(rank_k_r);

  assign out_load  = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || out_load;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    for (int i = 0; i < MAX_RANK; i++) begin
      rng[i]     = (RANK_W'(i) < k_eff);
      vld_vec[i] = links[i].vld;
    end
  end

  // the slot above cell 0 is always occupied and never overtaken
  assign head = '{gt: 1'b0, vld: 1'b1, val: '0};

  for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
    kls_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (in_acc),
      .in_rng   (rng[g]),
      .din      ($signed(in_tdata)),
      .link_in  ((g == 0) ? head : links[(g == 0) ? 0 : g - 1]),
      .link_out (links[g])
    );
  end

  kls_pick u_pick (
    .links     (links),
    .k_eff     (k_eff),
    .kth_value (pick_val),
    .full_res  (pick_full)
  );

  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_full_nxt  = out_full_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pick_val;
      out_full_nxt  = pick_full;
      pend_nxt      = 1'b0;
    end
    if (in_acc) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_k_r    <= RANK_W'(1);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rank_k_r    <= rank_k_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_full_r;

  // occupied cells always form a contiguous run from the head
  a_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_vec & (vld_vec + MAX_RANK'(1))) == '0)
    else $error("chain valid bits not contiguous");

  // never more values retained than the rank allows
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) <= int'(k_eff))
    else $error("chain holds more values than rank");

  // after an insertion the head cell holds a value
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> vld_vec[0])
    else $error("head cell empty after insertion");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for kth_largest_stream_tracker_core; keeps its own
// sorted top-k store per transaction and checks every result in order.
// Depends on kls_pkg and the core's rtl.
module tb;
  import kls_pkg::*;

  localparam int SETTLE = 4;  // cycles of quiet before a rank write

  typedef enum logic [1:0] {STEP_VALUE, STEP_RANK, STEP_DRAIN} feed_kind_t;

  typedef struct {
    feed_kind_t  kind;
    logic [31:0] data;
    int unsigned snd_idle;
    int unsigned rcv_stall;
  } feed_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] kth;
    logic                     full;
  } kth_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [RANK_W-1:0] cfg_data = '0;

  // sender idle / receiver stall percentages per idling mode
  int unsigned idle_snd [4] = '{0, 83, 0, 8};
  int unsigned idle_rcv [4] = '{0, 0, 83, 8};

  feed_item_t value_feed[$];
  kth_res_t   kth_exp_q[$];

  // predictor state
  logic signed [DATA_W-1:0] top_vals [0:MAX_RANK];
  int                       held_cnt = 0;
  logic [RANK_W-1:0]        rank_reg = RANK_W'(1);

  int unsigned rcv_stall = 0;
  int          sent_cnt = 0;
  int          got_cnt = 0;
  int          quiet_cnt = 0;
  int          mismatch_cnt = 0;

  kth_largest_stream_tracker_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // sorted insertion into the descending top-k store
  function automatic kth_res_t track_insert(input logic signed [DATA_W-1:0] v);
    int       k;
    int       pos;
    kth_res_t r;
    k = int'(rank_reg);
    if (k == 0) begin
      k = 1;
    end else if (k > MAX_RANK) begin
      k = MAX_RANK;
    end
    // surplus left from a rank decrease
    if (held_cnt > k) held_cnt = k;
    pos = held_cnt;
    while (pos > 0 && top_vals[pos-1] < v) begin
      top_vals[pos] = top_vals[pos-1];
      pos--;
    end
    top_vals[pos] = v;
    held_cnt++;
    if (held_cnt > k) held_cnt = k;
    r.kth  = top_vals[held_cnt-1];
    r.full = (held_cnt == k);
    return r;
  endfunction

  task automatic push_value(input logic [31:0] v, input int mode);
    feed_item_t it;
    it.kind      = STEP_VALUE;
    it.data      = v;
    it.snd_idle  = idle_snd[mode];
    it.rcv_stall = idle_rcv[mode];
    value_feed = {value_feed, it};
  endtask

  task automatic push_ctrl(input feed_kind_t kind, input logic [31:0] v);
    feed_item_t it;
    it.kind      = kind;
    it.data      = v;
    it.snd_idle  = 0;
    it.rcv_stall = 0;
    value_feed = {value_feed, it};
  endtask

  // driver: presents values and rank writes, predicts on each input transaction
  always @(posedge clk) begin
    bit go_val;
    bit go_cfg;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      rank_reg = RANK_W'(1);
      held_cnt = 0;
      quiet_cnt = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        kth_exp_q = {kth_exp_q, track_insert($signed(in_tdata))};
        sent_cnt++;
      end
      if (cfg_valid && cfg_ready) rank_reg = cfg_data;
      if (sent_cnt == got_cnt && !in_tvalid) quiet_cnt++;
      else quiet_cnt = 0;

      if (!((in_tvalid && !in_tready) || (cfg_valid && !cfg_ready))) begin
        go_val = 1'b0;
        go_cfg = 1'b0;
        if (value_feed.size() != 0) begin
          case (value_feed[0].kind)
            STEP_VALUE: begin
              if ($urandom_range(0, 99) >= value_feed[0].snd_idle) begin
                in_tdata  <= value_feed[0].data;
                rcv_stall <= value_feed[0].rcv_stall;
                go_val = 1'b1;
                value_feed.delete(0);
              end
            end
            STEP_RANK: begin
              if (quiet_cnt >= SETTLE) begin
                cfg_data <= value_feed[0].data[RANK_W-1:0];
                go_cfg = 1'b1;
                value_feed.delete(0);
              end
            end
            default: begin
              if (quiet_cnt >= SETTLE) value_feed.delete(0);
            end
          endcase
        end
        in_tvalid <= go_val;
        cfg_valid <= go_cfg;
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    kth_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_cnt <= got_cnt + 1;
        if (kth_exp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: kth_value %0d full %0b",
                     $signed(out_tdata), out_tuser);
        end else begin
          want = kth_exp_q.pop_front();
          if (out_tdata !== want.kth || out_tuser !== want.full) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: kth_value exp %0d got %0d, full exp %0b got %0b",
                       want.kth, $signed(out_tdata), want.full, out_tuser);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= rcv_stall);
    end
  end

  initial begin
    int          rank_plan [14];
    logic [31:0] dup_pool [4];
    logic [31:0] v;
    int          k;
    int          len;
    int          mode;

    rank_plan = '{127, 2, 64, 17, 65, 1, 0, 33, 100, 5, 8, 64, 3, 40};

    // directed: extremes at reset rank, duplicates, rank zero dropping surplus
    push_value(32'h0000_0000, 0);
    push_value(32'hFFFF_FFFF, 0);
    push_value(32'h7FFF_FFFF, 0);
    push_value(32'h8000_0000, 0);
    push_value(32'h0000_0001, 0);
    push_value(32'h7FFF_FFFF, 0);
    push_ctrl(STEP_RANK, 32'd4);
    push_value(32'd5, 0);
    push_value(32'd5, 0);
    push_value(32'd5, 0);
    push_value(32'h8000_0000, 0);
    push_value(32'd5, 0);
    push_value(-32'sd7, 0);
    push_value(32'hAAAA_AAAA, 0);
    push_value(32'h5555_5555, 0);
    push_value(32'h7FFF_FFFF, 0);
    push_value(32'h7FFF_FFFF, 0);
    push_ctrl(STEP_RANK, 32'd0);
    push_value(32'd3, 0);
    push_value(-32'sd3, 0);
    push_value(32'h8000_0000, 0);

    // random segments, one rank setting each
    foreach (rank_plan[s]) begin
      push_ctrl(STEP_RANK, rank_plan[s]);
      k = (rank_plan[s] == 0) ? 1 : (rank_plan[s] > MAX_RANK ? MAX_RANK : rank_plan[s]);
      len = k + $urandom_range(10, 40);
      foreach (dup_pool[j]) dup_pool[j] = $urandom;
      for (int i = 0; i < len; i++) begin
        mode = (s + ((i >= len / 2) ? 1 : 0)) % 4;
        if ((s == 3 && i == len / 2) || $urandom_range(0, 99) == 0)
          push_ctrl(STEP_DRAIN, 32'd0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: v = $urandom;
          4, 5:       v = $urandom_range(0, 15) - 8;
          6:          v = 32'h7FFF_FFFF - $urandom_range(0, 3);
          7:          v = 32'h8000_0000 + $urandom_range(0, 3);
          default:    v = dup_pool[$urandom_range(0, 3)];
        endcase
        push_value(v, mode);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (value_feed.size() != 0 || in_tvalid || cfg_valid) @(posedge clk);
    while (kth_exp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_cnt == 0 && kth_exp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/kls_pkg.sv
rtl/core/kls_cell.sv
rtl/core/kls_pick.sv
rtl/core/kth_largest_stream_tracker_core.sv
bench/tb.sv
